// ----- rtl/cmc_pkg.sv -----
// shared types, constants and helpers for the cpg methylation counter
`timescale 1ns / 1ps

package cmc_pkg;

    localparam int BASE_W  = 2;
    localparam int READ_W  = 16;
    localparam int THR_W   = 17;
    localparam int CNT_W   = 32;
    localparam int INC_W   = 2;

    // reference base codes, code three reads as other
    localparam logic [BASE_W-1:0] BASE_OTHER = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C     = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G     = 2'd2;

    // one input beat
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [READ_W-1:0] meth_reads;
        logic [READ_W-1:0] unmeth_reads;
        logic              seq_end;
    } t_item;

    // per-beat counter increments, at most two single sites per beat
    typedef struct packed {
        logic [INC_W-1:0] single_total;
        logic [INC_W-1:0] single_meth;
        logic [INC_W-1:0] single_unmeth;
        logic             pair_total;
        logic             pair_meth;
        logic             pair_unmeth;
    } t_inc;

    // the six running counters
    typedef struct packed {
        logic [CNT_W-1:0] single_total;
        logic [CNT_W-1:0] single_meth;
        logic [CNT_W-1:0] single_unmeth;
        logic [CNT_W-1:0] pair_total;
        logic [CNT_W-1:0] pair_meth;
        logic [CNT_W-1:0] pair_unmeth;
    } t_counts;

    // saturating add of a small increment
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [INC_W-1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W+1-INC_W){1'b0}}, inc};
        if (sum[CNT_W]) begin
            return {CNT_W{1'b1}};
        end
        return sum[CNT_W-1:0];
    endfunction

endpackage

// ----- rtl/cmc_in_reg.sv -----
// input register stage with stall toward the upstream side
`timescale 1ns / 1ps

module cmc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cmc_pkg::t_item i_item,
    input  logic          i_out_free,
    output cmc_pkg::t_item o_item,
    output logic          o_move
);
    import cmc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    // stage moves on when the result side can take it
    assign o_move  = r_valid && i_out_free;
    assign o_stall = r_valid && !i_out_free;
    assign load    = i_valid && !o_stall;
    assign o_item  = r_item;

    // next valid
    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_move) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/cmc_site_logic.sv -----
// pending c tracking and site classification for one beat
`timescale 1ns / 1ps

module cmc_site_logic (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cmc_pkg::t_item            i_item,
    input  logic                      i_move,
    input  logic [cmc_pkg::THR_W-1:0] i_call_thr,
    output cmc_pkg::t_inc             o_inc
);
    import cmc_pkg::*;

    logic              r_pend;
    logic [READ_W-1:0] r_pend_meth;
    logic [READ_W-1:0] r_pend_unmeth;
    logic              n_pend;

    logic              is_c;
    logic              is_g;
    logic              pair;
    logic              pend_single;
    logic              cur_single;
    logic [THR_W-1:0]  sum_meth;
    logic [THR_W-1:0]  sum_unmeth;
    logic [THR_W-1:0]  pm_ext;
    logic [THR_W-1:0]  pu_ext;
    logic [THR_W-1:0]  cm_ext;
    logic [THR_W-1:0]  cu_ext;
    logic              ps_meth;
    logic              ps_unmeth;
    logic              cs_meth;
    logic              cs_unmeth;
    logic              pr_meth;
    logic              pr_unmeth;

    // decode the base and the kind of site it closes
    assign is_c        = (i_item.base == BASE_C);
    assign is_g        = (i_item.base == BASE_G);
    assign pair        = r_pend && is_g;
    assign pend_single = r_pend && !is_g;
    assign cur_single  = !pair && (is_g || (is_c && i_item.seq_end));
    assign n_pend      = is_c && !i_item.seq_end;

    // read counts widened to threshold width
    assign pm_ext     = {1'b0, r_pend_meth};
    assign pu_ext     = {1'b0, r_pend_unmeth};
    assign cm_ext     = {1'b0, i_item.meth_reads};
    assign cu_ext     = {1'b0, i_item.unmeth_reads};
    assign sum_meth   = pm_ext + cm_ext;
    assign sum_unmeth = pu_ext + cu_ext;

    // methylated first, unmethylated only if that fails
    assign ps_meth   = pm_ext >= i_call_thr;
    assign ps_unmeth = !ps_meth && (pu_ext >= i_call_thr);
    assign cs_meth   = cm_ext >= i_call_thr;
    assign cs_unmeth = !cs_meth && (cu_ext >= i_call_thr);
    assign pr_meth   = sum_meth >= i_call_thr;
    assign pr_unmeth = !pr_meth && (sum_unmeth >= i_call_thr);

    // increments for the counters
    always_comb begin
        o_inc.single_total  = {1'b0, pend_single} + {1'b0, cur_single};
        o_inc.single_meth   = {1'b0, pend_single && ps_meth}
                            + {1'b0, cur_single && cs_meth};
        o_inc.single_unmeth = {1'b0, pend_single && ps_unmeth}
                            + {1'b0, cur_single && cs_unmeth};
        o_inc.pair_total    = pair;
        o_inc.pair_meth     = pair && pr_meth;
        o_inc.pair_unmeth   = pair && pr_unmeth;
    end

    // pending c flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_move) begin
            r_pend <= n_pend;
        end
    end

    // pending c read counts
    always_ff @(posedge i_clk) begin
        if (i_move && n_pend) begin
            r_pend_meth   <= i_item.meth_reads;
            r_pend_unmeth <= i_item.unmeth_reads;
        end
    end

endmodule

// ----- rtl/cmc_counters.sv -----
// saturating site counters, which also serve as the result register
`timescale 1ns / 1ps

module cmc_counters (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_move,
    input  cmc_pkg::t_inc    i_inc,
    input  logic             i_stall,
    output cmc_pkg::t_counts o_counts,
    output logic             o_valid,
    output logic             o_out_free
);
    import cmc_pkg::*;

    t_counts r_cnt;
    t_counts n_cnt;
    logic    r_valid;
    logic    n_valid;

    assign o_counts   = r_cnt;
    assign o_valid    = r_valid;
    assign o_out_free = !r_valid || !i_stall;

    // next counter values
    always_comb begin
        n_cnt.single_total  = sat_add(r_cnt.single_total,  i_inc.single_total);
        n_cnt.single_meth   = sat_add(r_cnt.single_meth,   i_inc.single_meth);
        n_cnt.single_unmeth = sat_add(r_cnt.single_unmeth, i_inc.single_unmeth);
        n_cnt.pair_total    = sat_add(r_cnt.pair_total,    {1'b0, i_inc.pair_total});
        n_cnt.pair_meth     = sat_add(r_cnt.pair_meth,     {1'b0, i_inc.pair_meth});
        n_cnt.pair_unmeth   = sat_add(r_cnt.pair_unmeth,   {1'b0, i_inc.pair_unmeth});
    end

    // result valid
    always_comb begin
        n_valid = r_valid;
        if (i_move) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    // counters and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_move) begin
                r_cnt <= n_cnt;
            end
        end
    end

    // a site is never called more often than it is counted
    a_single_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt.single_meth} + {1'b0, r_cnt.single_unmeth})
            <= {1'b0, r_cnt.single_total})
        else $error("single site calls exceed single site count");

    a_pair_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt.pair_meth} + {1'b0, r_cnt.pair_unmeth})
            <= {1'b0, r_cnt.pair_total})
        else $error("cpg calls exceed cpg count");

    // at most one cpg closes per beat
    a_pair_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_cnt.pair_total - $past(r_cnt.pair_total)) <= 1))
        else $error("cpg count stepped by more than one");

    // counters move only with a beat into the result register
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_move |=> $stable(r_cnt))
        else $error("counters changed without a beat");

endmodule

// ----- rtl/cpg_methylation_counter_core.sv -----
// top level of the cpg methylation counter
//
//  channel   dir  handshake                 payload
//  input     in   i_valid / o_stall         i_base, i_meth_reads, i_unmeth_reads, i_seq_end
//  result    out  o_valid / i_stall         o_single_*, o_pair_* (32 bits each)
//  config    in   i_cfg_valid / o_cfg_ready i_cfg_data (call threshold, 17 bits)
//
// one beat per cycle while no stall holds the flow; a result passes through
// the input register, then the counter register that holds the result
// reset clears the pending c, the six counters and the call threshold
// a stalled result holds the counters; the input register still takes one beat
// config is always ready; the user must write it only while the block is idle (not enforced)
`timescale 1ns / 1ps

module cpg_methylation_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cmc_pkg::BASE_W-1:0]    i_base,
    input  logic [cmc_pkg::READ_W-1:0]    i_meth_reads,
    input  logic [cmc_pkg::READ_W-1:0]    i_unmeth_reads,
    input  logic                          i_seq_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cmc_pkg::CNT_W-1:0]     o_single_total,
    output logic [cmc_pkg::CNT_W-1:0]     o_single_meth,
    output logic [cmc_pkg::CNT_W-1:0]     o_single_unmeth,
    output logic [cmc_pkg::CNT_W-1:0]     o_pair_total,
    output logic [cmc_pkg::CNT_W-1:0]     o_pair_meth,
    output logic [cmc_pkg::CNT_W-1:0]     o_pair_unmeth,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cmc_pkg::THR_W-1:0]     i_cfg_data
);
    import cmc_pkg::*;

    logic [THR_W-1:0] r_call_thr;
    t_item            in_item;
    t_item            s1_item;
    logic             s1_move;
    logic             out_free;
    t_inc             inc;
    t_counts          counts;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_call_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_call_thr <= i_cfg_data;
        end
    end

    // input beat
    assign in_item.base         = i_base;
    assign in_item.meth_reads   = i_meth_reads;
    assign in_item.unmeth_reads = i_unmeth_reads;
    assign in_item.seq_end      = i_seq_end;

    cmc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_item     (s1_item),
        .o_move     (s1_move)
    );

    cmc_site_logic u_site_logic (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (s1_item),
        .i_move      (s1_move),
        .i_call_thr  (r_call_thr),
        .o_inc       (inc)
    );

    cmc_counters u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_move     (s1_move),
        .i_inc      (inc),
        .i_stall    (i_stall),
        .o_counts   (counts),
        .o_valid    (o_valid),
        .o_out_free (out_free)
    );

    // result beat
    assign o_single_total  = counts.single_total;
    assign o_single_meth   = counts.single_meth;
    assign o_single_unmeth = counts.single_unmeth;
    assign o_pair_total    = counts.pair_total;
    assign o_pair_meth     = counts.pair_meth;
    assign o_pair_unmeth   = counts.pair_unmeth;

endmodule
